// ===== rtl/rma_pkg.sv =====
// Shared types, sizes and constants of the rectified moving average block.
package rma_pkg;

   localparam int unsigned WINDOW   = 10;
   localparam int unsigned CHANNELS = 8;

   localparam int unsigned CHAN_W   = 3;
   localparam int unsigned SAMPLE_W = 8;
   localparam int unsigned SUM_OUT_W = 11;
   localparam int unsigned MEAN_W   = 16;
   localparam int unsigned SUM_OUT_MAX = 2047;

   localparam int unsigned CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int unsigned SLOT_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int unsigned CNT_W    = $clog2(WINDOW + 1);
   localparam int unsigned RING_DEPTH = CHANNELS * WINDOW;
   localparam int unsigned ADDR_W   = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

   localparam int unsigned SUM_W    = $clog2(WINDOW * 128 + 1);
   localparam int unsigned LOG_W    = $clog2(WINDOW);
   localparam int unsigned MUL_SHIFT = SUM_W + LOG_W;
   localparam int unsigned RECIP_W  = SUM_W + 9;
   localparam longint unsigned RECIP =
      ((64'd1 << (MUL_SHIFT + 8)) + WINDOW - 1) / WINDOW;
   localparam int unsigned PROD_W   = SUM_W + RECIP_W;

   typedef logic [CHAN_W-1:0]          chan_type;
   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic [SAMPLE_W-1:0]        mag_type;
   typedef logic [SUM_W-1:0]           sum_type;
   typedef logic [SUM_OUT_W-1:0]       sum_out_type;
   typedef logic [MEAN_W-1:0]          mean_type;

   // Word leaving the channel state stage.
   typedef struct packed {
      chan_type ch;
      logic     in_range;
      logic     first;
      logic     use_fill;
      mag_type  mag;
      mag_type  fill;
      mag_type  oldest_ring;
   } ctl_word_type;

   // Word leaving the accumulate stage.
   typedef struct packed {
      chan_type ch;
      sum_type  sum;
   } acc_word_type;

endpackage

// ===== rtl/rma_if.sv =====
// Stream interfaces for the sample input and the result output.
interface rma_req_if;
   logic                 valid;
   logic                 ready;
   rma_pkg::chan_type    channel;
   rma_pkg::sample_type  sample;

   modport source (output valid, output channel, output sample, input ready);
   modport sink (input valid, input channel, input sample, output ready);
endinterface

interface rma_rsp_if;
   logic                  valid;
   logic                  ready;
   rma_pkg::chan_type     channel_out;
   rma_pkg::sum_out_type  window_sum;
   rma_pkg::mean_type     mean_q8;

   modport source (output valid, output channel_out, output window_sum,
                   output mean_q8, input ready);
   modport sink (input valid, input channel_out, input window_sum,
                 input mean_q8, output ready);
endinterface

// ===== rtl/rma_ctl.sv =====
// Per-channel window bookkeeping and the sample history memory.
module rma_ctl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  rma_pkg::chan_type     req_channel,
   input  rma_pkg::sample_type   req_sample,
   output logic                  req_ready,
   output logic                  ctl_valid,
   output rma_pkg::ctl_word_type ctl_word,
   input  logic                  ctl_ready
);
   import rma_pkg::*;

   logic                primed_ff [CHANNELS];
   logic [SLOT_W-1:0]   slot_ff   [CHANNELS];
   logic [CNT_W-1:0]    count_ff  [CHANNELS];
   mag_type             fill_ff   [CHANNELS];
   mag_type             ring      [RING_DEPTH];

   logic                valid_ff;
   chan_type            ch_ff;
   logic                in_range_ff;
   logic                first_ff;
   logic                use_fill_ff;
   mag_type             mag_ff;
   mag_type             fill_out_ff;
   mag_type             ring_rd_ff;

   logic                accept;
   logic                in_range;
   logic [CH_IDX_W-1:0] idx;
   mag_type             mag;
   logic                primed;
   logic [SLOT_W-1:0]   slot;
   logic [CNT_W-1:0]    count;
   logic                filling;
   logic [SLOT_W-1:0]   slot_in;
   logic [CNT_W-1:0]    count_in;
   logic [ADDR_W-1:0]   addr;
   logic                ring_wr;

   assign req_ready = !valid_ff || ctl_ready;
   assign accept    = req_valid && req_ready;
   assign in_range  = 32'(req_channel) < CHANNELS;
   assign idx       = req_channel[CH_IDX_W-1:0];
   assign mag       = req_sample[SAMPLE_W-1] ? SAMPLE_W'(~req_sample + 1'b1)
                                             : SAMPLE_W'(req_sample);
   assign primed    = primed_ff[idx];
   assign slot      = slot_ff[idx];
   assign count     = count_ff[idx];
   assign filling   = 32'(count) < WINDOW;
   assign slot_in   = (32'(slot) == WINDOW - 1) ? '0 : slot + 1'b1;
   assign count_in  = filling ? count + 1'b1 : count;
   assign addr      = ADDR_W'(idx) * ADDR_W'(WINDOW) + ADDR_W'(slot);
   assign ring_wr   = accept && in_range && primed;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            primed_ff[i] <= 1'b0;
            slot_ff[i]   <= '0;
            count_ff[i]  <= '0;
            fill_ff[i]   <= '0;
         end
      end else begin
         if (req_ready) begin
            valid_ff <= req_valid;
         end
         if (accept && in_range) begin
            if (!primed) begin
               primed_ff[idx] <= 1'b1;
               fill_ff[idx]   <= mag;
               slot_ff[idx]   <= '0;
               count_ff[idx]  <= '0;
            end else begin
               slot_ff[idx]  <= slot_in;
               count_ff[idx] <= count_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ch_ff       <= req_channel;
         in_range_ff <= in_range;
         first_ff    <= !primed;
         use_fill_ff <= filling;
         mag_ff      <= mag;
         fill_out_ff <= fill_ff[idx];
      end
   end

   // The read returns the entry as it was before this cycle's write.
   always_ff @(posedge clock) begin
      if (accept) begin
         ring_rd_ff <= ring[addr];
      end
      if (ring_wr) begin
         ring[addr] <= mag;
      end
   end

   assign ctl_valid = valid_ff;
   always_comb begin
      ctl_word.ch          = ch_ff;
      ctl_word.in_range    = in_range_ff;
      ctl_word.first       = first_ff;
      ctl_word.use_fill    = use_fill_ff;
      ctl_word.mag         = mag_ff;
      ctl_word.fill        = fill_out_ff;
      ctl_word.oldest_ring = ring_rd_ff;
   end

endmodule

// ===== rtl/rma_acc.sv =====
// Running window sum per channel, updated once per word.
module rma_acc (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  ctl_valid,
   input  rma_pkg::ctl_word_type ctl_word,
   output logic                  ctl_ready,
   output logic                  acc_valid,
   output rma_pkg::acc_word_type acc_word,
   input  logic                  acc_ready
);
   import rma_pkg::*;

   sum_type             sum_ff [CHANNELS];
   logic                valid_ff;
   acc_word_type        word_ff;

   logic                advance;
   logic [CH_IDX_W-1:0] idx;
   mag_type             oldest;
   logic [SUM_W:0]      grown;
   sum_type             sum_in;

   assign ctl_ready = !valid_ff || acc_ready;
   assign advance   = ctl_valid && ctl_ready;
   assign idx       = ctl_word.ch[CH_IDX_W-1:0];
   assign oldest    = ctl_word.use_fill ? ctl_word.fill : ctl_word.oldest_ring;
   assign grown     = {1'b0, sum_ff[idx]} + (SUM_W + 1)'(ctl_word.mag)
                      - (SUM_W + 1)'(oldest);

   always_comb begin
      if (ctl_word.first) begin
         sum_in = SUM_W'(ctl_word.mag) * SUM_W'(WINDOW);
      end else begin
         sum_in = grown[SUM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            sum_ff[i] <= '0;
         end
      end else begin
         if (ctl_ready) begin
            valid_ff <= ctl_valid;
         end
         if (advance && ctl_word.in_range) begin
            sum_ff[idx] <= sum_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         word_ff.ch  <= ctl_word.ch;
         word_ff.sum <= ctl_word.in_range ? sum_in : '0;
      end
   end

   assign acc_valid = valid_ff;
   assign acc_word  = word_ff;

endmodule

// ===== rtl/rma_mean.sv =====
// Mean by reciprocal multiplication and the result register.
module rma_mean (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  acc_valid,
   input  rma_pkg::acc_word_type acc_word,
   output logic                  acc_ready,
   output logic                  rsp_valid,
   output rma_pkg::chan_type     rsp_channel_out,
   output rma_pkg::sum_out_type  rsp_window_sum,
   output rma_pkg::mean_type     rsp_mean_q8,
   input  logic                  rsp_ready
);
   import rma_pkg::*;

   logic              valid_ff;
   chan_type          ch_ff;
   sum_out_type       sum_ff;
   logic [PROD_W-1:0] prod_ff;

   logic              advance;
   logic [31:0]       sum_wide;
   sum_out_type       sum_sat;
   logic [PROD_W-1:0] prod_in;

   assign acc_ready = !valid_ff || rsp_ready;
   assign advance   = acc_valid && acc_ready;
   assign sum_wide  = 32'(acc_word.sum);
   assign sum_sat   = (sum_wide > SUM_OUT_MAX) ? SUM_OUT_W'(SUM_OUT_MAX)
                                               : sum_wide[SUM_OUT_W-1:0];
   // The reciprocal is rounded up far enough that the truncated quotient is exact.
   assign prod_in   = PROD_W'(acc_word.sum) * PROD_W'(RECIP_W'(RECIP));

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (acc_ready) begin
         valid_ff <= acc_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ch_ff   <= acc_word.ch;
         sum_ff  <= sum_sat;
         prod_ff <= prod_in;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_channel_out = ch_ff;
   assign rsp_window_sum  = sum_ff;
   assign rsp_mean_q8     = prod_ff[MUL_SHIFT +: MEAN_W];

endmodule

// ===== rtl/rectified_moving_average.sv =====
// Top level of the per-channel rectified moving average.
// Each word carries a channel and a signed sample; the block rectifies the sample and returns
// one result word per input word with the channel, the sum of the last WINDOW rectified
// samples of that channel and the mean with 8 fractional bits, truncated. A channel's first
// sample fills its whole window. The pipeline has three register stages (channel state and
// history memory read, sum update, reciprocal multiply), and one word is taken every cycle
// unless the result side stalls, also back to back on the same channel. Stalls on the result
// side back up stage by stage, so empty stages keep taking input while a result waits.
module rectified_moving_average (
   input  logic clock,
   input  logic reset,
   rma_req_if.sink   req_if,
   rma_rsp_if.source rsp_if
);
   import rma_pkg::*;

   logic         ctl_valid;
   logic         ctl_ready;
   ctl_word_type ctl_word;
   logic         acc_valid;
   logic         acc_ready;
   acc_word_type acc_word;

   rma_ctl u_ctl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_if.valid),
      .req_channel (req_if.channel),
      .req_sample  (req_if.sample),
      .req_ready   (req_if.ready),
      .ctl_valid   (ctl_valid),
      .ctl_word    (ctl_word),
      .ctl_ready   (ctl_ready)
   );

   rma_acc u_acc (
      .clock     (clock),
      .reset     (reset),
      .ctl_valid (ctl_valid),
      .ctl_word  (ctl_word),
      .ctl_ready (ctl_ready),
      .acc_valid (acc_valid),
      .acc_word  (acc_word),
      .acc_ready (acc_ready)
   );

   rma_mean u_mean (
      .clock           (clock),
      .reset           (reset),
      .acc_valid       (acc_valid),
      .acc_word        (acc_word),
      .acc_ready       (acc_ready),
      .rsp_valid       (rsp_if.valid),
      .rsp_channel_out (rsp_if.channel_out),
      .rsp_window_sum  (rsp_if.window_sum),
      .rsp_mean_q8     (rsp_if.mean_q8),
      .rsp_ready       (rsp_if.ready)
   );

endmodule

// ===== sim/rectified_moving_average_test.sv =====
// Self-checking testbench for the per-channel rectified moving average block.
module rectified_moving_average_test;
   import rma_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 200000;
   localparam int unsigned RANDOM_WORDS = 1000;
   localparam int unsigned HOLD_AFTER   = 300;
   localparam int unsigned HOLD_CYCLES  = 300;
   localparam int unsigned DRAIN_CYCLES = 12;
   localparam int unsigned DIR_ROWS     = 20;

   typedef struct packed {
      chan_type    ch;
      sum_out_type sum;
      mean_type    mean;
   } avg_word_type;

   typedef struct {
      chan_type    ch;
      sample_type  smp;
      bit          known;
      sum_out_type sum;
      mean_type    mean;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rma_req_if req_bus ();
   rma_rsp_if rsp_bus ();

   rectified_moving_average u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   always #2 clock = ~clock;

   // Channel state of the predictor.
   logic [SAMPLE_W-1:0] ring_copy [CHANNELS][WINDOW];
   int unsigned         acc_sum [CHANNELS];
   int unsigned         next_slot [CHANNELS];
   int unsigned         real_seen [CHANNELS];
   int unsigned         first_mag [CHANNELS];
   bit                  primed_copy [CHANNELS];

   avg_word_type pending_averages [$];
   int unsigned  mismatches = 0;
   int unsigned  accepted_words = 0;
   int unsigned  burst_left = 0;

   // First samples fill the whole window, so their results can be typed in directly.
   stim_row_type dir_rows [DIR_ROWS] = '{
      '{0, -128, 1, 1280, 32768},
      '{1,  127, 1, 1270, 32512},
      '{2,    0, 1,    0,     0},
      '{3,   -1, 1,   10,   256},
      '{4,    1, 1,   10,   256},
      '{0,  127, 0,    0,     0},
      '{0, -128, 0,    0,     0},
      '{0,    0, 0,    0,     0},
      '{0,    1, 0,    0,     0},
      '{0,   -1, 0,    0,     0},
      '{0,   85, 0,    0,     0},
      '{0,  -86, 0,    0,     0},
      '{0,   42, 0,    0,     0},
      '{0,  100, 0,    0,     0},
      '{0, -100, 0,    0,     0},
      '{0,    5, 0,    0,     0},
      '{0,   -2, 0,    0,     0},
      '{5, -128, 1, 1280, 32768},
      '{6,   64, 1,  640, 16384},
      '{7, -127, 1, 1270, 32512}
   };

   function automatic avg_word_type predict_average(chan_type ch, sample_type smp);
      avg_word_type res;
      int unsigned  mag;
      int unsigned  oldest;
      int unsigned  slot;
      int unsigned  total;
      res.ch = ch;
      res.sum = '0;
      res.mean = '0;
      if (ch >= CHANNELS) begin
         return res;
      end
      mag = (smp < 0) ? -int'(smp) : int'(smp);
      if (!primed_copy[ch]) begin
         primed_copy[ch] = 1'b1;
         first_mag[ch] = mag;
         acc_sum[ch] = mag * WINDOW;
         real_seen[ch] = 0;
         next_slot[ch] = 0;
      end else begin
         slot = next_slot[ch] % WINDOW;
         oldest = (real_seen[ch] < WINDOW) ? first_mag[ch] : int'(ring_copy[ch][slot]);
         ring_copy[ch][slot] = SAMPLE_W'(mag);
         next_slot[ch] = (slot + 1) % WINDOW;
         if (real_seen[ch] < WINDOW) begin
            real_seen[ch]++;
         end
         acc_sum[ch] = acc_sum[ch] + mag - oldest;
      end
      total = acc_sum[ch];
      res.sum = (total > SUM_OUT_MAX) ? SUM_OUT_W'(SUM_OUT_MAX) : SUM_OUT_W'(total);
      res.mean = MEAN_W'((total * 256) / WINDOW);
      return res;
   endfunction

   task automatic report_mismatch(string what, int unsigned want, int unsigned got);
      $display("MISMATCH %s: expected %0d, got %0d (pending %0d)", what, want, got,
               pending_averages.size());
      mismatches++;
   endtask

   // Offers one word, inserting a random gap whenever a burst runs out.
   task automatic send_sample(chan_type ch, sample_type smp);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_bus.valid   <= 1'b1;
      req_bus.channel <= ch;
      req_bus.sample  <= smp;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      burst_left--;
      accepted_words++;
   endtask

   task automatic send_and_predict(chan_type ch, sample_type smp);
      send_sample(ch, smp);
      pending_averages.push_back(predict_average(ch, smp));
   endtask

   initial begin : stimulus
      int unsigned  n;
      int unsigned  run;
      chan_type     ch;
      sample_type   smp;
      avg_word_type want;
      for (int c = 0; c < CHANNELS; c++) begin
         acc_sum[c] = 0;
         next_slot[c] = 0;
         real_seen[c] = 0;
         first_mag[c] = 0;
         primed_copy[c] = 1'b0;
      end
      req_bus.valid = 1'b0;
      req_bus.channel = '0;
      req_bus.sample = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         send_sample(dir_rows[i].ch, dir_rows[i].smp);
         want = predict_average(dir_rows[i].ch, dir_rows[i].smp);
         if (dir_rows[i].known) begin
            want.sum = dir_rows[i].sum;
            want.mean = dir_rows[i].mean;
         end
         pending_averages.push_back(want);
      end

      n = 0;
      while (n < RANDOM_WORDS) begin
         ch = CHAN_W'($urandom_range(0, CHANNELS - 1));
         run = ($urandom_range(0, 2) == 0) ? 1 : $urandom_range(1, 16);
         for (int k = 0; k < run; k++) begin
            case ($urandom_range(0, 11))
               0: smp = SAMPLE_W'(-128);
               1: smp = SAMPLE_W'(127);
               2: smp = '0;
               3: smp = SAMPLE_W'(-1);
               default: smp = SAMPLE_W'($urandom_range(0, 255));
            endcase
            if ($urandom_range(0, 4) == 0) begin
               ch = CHAN_W'($urandom_range(0, CHANNELS - 1));
            end
            send_and_predict(ch, smp);
            n++;
         end
      end
      req_bus.valid <= 1'b0;

      while (pending_averages.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Receiver: checks each result word and stalls on a pattern of its own.
   initial begin : receiver
      logic [15:0]  stall_bits;
      int unsigned  phase;
      int unsigned  hold_left;
      bit           held_once;
      avg_word_type want;
      stall_bits = 16'hffff;
      phase = 0;
      hold_left = 0;
      held_once = 1'b0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            if (pending_averages.size() == 0) begin
               report_mismatch("unexpected word, channel", 0, rsp_bus.channel_out);
            end else begin
               want = pending_averages.pop_front();
               if (rsp_bus.channel_out !== want.ch)
                  report_mismatch("channel_out", want.ch, rsp_bus.channel_out);
               if (rsp_bus.window_sum !== want.sum)
                  report_mismatch("window_sum", want.sum, rsp_bus.window_sum);
               if (rsp_bus.mean_q8 !== want.mean)
                  report_mismatch("mean_q8", want.mean, rsp_bus.mean_q8);
            end
         end
         if (!held_once && accepted_words >= HOLD_AFTER) begin
            held_once = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (phase % 64 == 0) begin
            stall_bits = ($urandom_range(0, 3) == 0) ? 16'hffff : 16'($urandom);
         end
         phase++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= stall_bits[phase % 16];
         end
      end
   end

   initial begin : watchdog
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("TEST FAILED");
      $finish;
   end

endmodule
